### rtl/xild_pkg.sv
// ----------------------------------------------------------------------------
// xild_pkg
// Opcode flag tables, phase codes and shared types for the length decoder.
// ----------------------------------------------------------------------------
package xild_pkg;

   localparam logic [7:0] F_N = 8'h00;
   localparam logic [7:0] F_M = 8'h01;
   localparam logic [7:0] F_B = 8'h02;
   localparam logic [7:0] F_W = 8'h04;
   localparam logic [7:0] F_P = 8'h08;
   localparam logic [7:0] F_X = 8'h10;

   localparam logic [7:0] OPC_TWO_BYTE = 8'h0F;
   localparam logic [7:0] OPC_INT3     = 8'hCC;
   localparam logic [7:0] OPC_NOP      = 8'h90;
   localparam logic [7:0] OPC_TEST8    = 8'hF6;
   localparam logic [7:0] OPC_TEST32   = 8'hF7;
   localparam logic [7:0] OPC_OPSIZE   = 8'h66;
   localparam logic [7:0] OPC_ADSIZE   = 8'h67;

   localparam logic CSR_MAX_PREFIXES = 1'b0;
   localparam logic CSR_FILLER_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_EXT    = 3'd1,
      PH_WORD   = 3'd2,
      PH_MODRM  = 3'd3,
      PH_SIB    = 3'd4,
      PH_TAIL   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [4:0] insn_length;
      logic [7:0] opcode_byte;
      logic [15:0] total_size;
      logic       walk_end;
      logic       prefix_error;
   } result_type;

   function automatic logic is_prefix(input logic [7:0] b);
      return b == 8'h2E || b == 8'h3E || b == 8'h36 || b == 8'h26 ||
             b == 8'h64 || b == 8'h65 || b == 8'hF0 || b == 8'hF2 ||
             b == 8'hF3 || b == 8'h66 || b == 8'h67;
   endfunction

   function automatic logic [7:0] tbl_one(input logic [7:0] b);
      logic [7:0] f;
      f = F_N;
      if (b < 8'h40) begin
         case (b[2:0])
            3'd0, 3'd1, 3'd2, 3'd3: f = F_M;
            3'd4:                   f = F_B;
            3'd5:                   f = F_P;
            default:                f = F_N;
         endcase
      end else if (b >= 8'h70 && b <= 8'h7F) begin
         f = F_B;
      end else if (b >= 8'h84 && b <= 8'h8F) begin
         f = F_M;
      end else if (b >= 8'hB0 && b <= 8'hB7) begin
         f = F_B;
      end else if (b >= 8'hB8 && b <= 8'hBF) begin
         f = F_P;
      end else if (b >= 8'hD8 && b <= 8'hDF) begin
         f = F_X;
      end else if (b >= 8'hE0 && b <= 8'hE7) begin
         f = F_B;
      end else begin
         case (b)
            8'h62, 8'h63: f = F_M;
            8'h68:        f = F_P;
            8'h69:        f = F_M | F_P;
            8'h6A:        f = F_B;
            8'h6B:        f = F_M | F_B;
            8'h80, 8'h82, 8'h83: f = F_M | F_B;
            8'h81:        f = F_M | F_P;
            8'h9A:        f = F_W | F_P;
            8'hA0, 8'hA1, 8'hA2, 8'hA3: f = F_P;
            8'hA8:        f = F_B;
            8'hA9:        f = F_P;
            8'hC0, 8'hC1, 8'hC6: f = F_M | F_B;
            8'hC2, 8'hCA: f = F_W;
            8'hC4, 8'hC5: f = F_M;
            8'hC7:        f = F_M | F_P;
            8'hC8:        f = F_B | F_W;
            8'hCD:        f = F_B;
            8'hD0, 8'hD1, 8'hD2, 8'hD3: f = F_M;
            8'hD4, 8'hD5: f = F_B;
            8'hE8, 8'hE9: f = F_P;
            8'hEA:        f = F_W | F_P;
            8'hEB:        f = F_B;
            8'hF6, 8'hF7, 8'hFE, 8'hFF: f = F_M;
            default:      f = F_N;
         endcase
      end
      return f;
   endfunction

   function automatic logic [7:0] tbl_two(input logic [7:0] b);
      logic [7:0] f;
      f = F_M;
      if (b >= 8'h30 && b <= 8'h3F) begin
         f = F_N;
      end else if (b >= 8'h80 && b <= 8'h8F) begin
         f = F_P;
      end else if (b >= 8'hC8 && b <= 8'hCF) begin
         f = F_N;
      end else begin
         case (b)
            8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
            8'h0C, 8'h0E: f = F_N;
            8'h0F:        f = F_M | F_B;
            8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F: f = F_N;
            8'h25, 8'h27: f = F_N;
            8'h70, 8'h71, 8'h72, 8'h73: f = F_M | F_B;
            8'h77, 8'h78, 8'h79, 8'h7A, 8'h7B: f = F_N;
            8'hA0, 8'hA1, 8'hA2, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA: f = F_N;
            8'hA4, 8'hAC: f = F_M | F_B;
            8'hB8, 8'hB9: f = F_N;
            8'hBA:        f = F_M | F_B;
            8'hC2, 8'hC4, 8'hC5, 8'hC6: f = F_M | F_B;
            8'hFF:        f = F_N;
            default:      f = F_M;
         endcase
      end
      return f;
   endfunction

endpackage

### rtl/xild_core.sv
// ----------------------------------------------------------------------------
// xild_core
// Per-byte decode step: phase machine, length and running total.
// ----------------------------------------------------------------------------
module xild_core import xild_pkg::*; #(
   parameter int TOTAL_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       code_byte,
   input  logic             walk_start,
   input  logic [4:0]       max_prefixes,
   input  logic [3:0]       filler_limit,
   output logic             res_valid,
   output result_type       res
);

   phase_type phase_ff, phase_in;
   logic [7:0] flags_ff, flags_in;
   logic       opsz_ff, opsz_in, adsz_ff, adsz_in;
   logic [7:0] opc_ff, opc_in;
   logic [1:0] mod_ff, mod_in;
   logic [3:0] left_ff, left_in;
   logic [4:0] len_ff, len_in;
   logic [4:0] pfx_ff, pfx_in;
   logic [3:0] fill_ff, fill_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic       done_ff, done_in;

   always_comb begin
      logic [7:0] fl;
      logic       opsz, adsz, fin, ovf, endw, sib;
      logic [3:0] off, imm;
      logic [4:0] len;
      logic [3:0] fill;
      logic [TOTAL_BITS:0] sum;
      phase_type  ph;
      logic [2:0] reg_f, rm;
      phase_in = phase_ff; flags_in = flags_ff; opsz_in = opsz_ff; adsz_in = adsz_ff;
      opc_in = opc_ff; mod_in = mod_ff; left_in = left_ff; len_in = len_ff;
      pfx_in = pfx_ff; fill_in = fill_ff; total_in = total_ff; done_in = done_ff;
      res_valid = 1'b0;
      res = '0;
      fin = 1'b0; ovf = 1'b0;
      fl = flags_ff; opsz = opsz_ff; adsz = adsz_ff;
      off = '0; imm = '0; sib = 1'b0; endw = 1'b0; sum = '0;
      reg_f = code_byte[5:3]; rm = code_byte[2:0];
      ph = phase_ff; len = len_ff; fill = fill_ff;
      if (walk_start && step) begin
         total_in = '0; fill_in = '0; done_in = 1'b0;
         ph = PH_PREFIX; fl = '0; opsz = 1'b0; adsz = 1'b0; opc_in = '0;
         mod_in = '0; left_in = '0; len = '0; pfx_in = '0;
         fill = '0;
      end
      if (step && !(done_ff && !walk_start)) begin
         if (len != 5'd31) len = len + 5'd1;
         len_in = len; flags_in = fl; opsz_in = opsz; adsz_in = adsz;
         phase_in = ph;
         case (ph)
            PH_EXT: begin
               fl = tbl_two(code_byte); flags_in = fl;
               if (fl[4]) phase_in = PH_WORD;
               else if (fl[0]) phase_in = PH_MODRM;
               else begin
                  imm = {3'd0, fl[1]} + {2'd0, fl[2], 1'b0} +
                        (fl[3] ? (opsz ? 4'd2 : 4'd4) : 4'd0);
                  left_in = imm;
                  if (imm == '0) fin = 1'b1; else phase_in = PH_TAIL;
               end
            end
            PH_WORD: begin
               if (fl[0]) phase_in = PH_MODRM;
               else begin
                  imm = {3'd0, fl[1]} + {2'd0, fl[2], 1'b0} +
                        (fl[3] ? (opsz ? 4'd2 : 4'd4) : 4'd0);
                  left_in = imm;
                  if (imm == '0) fin = 1'b1; else phase_in = PH_TAIL;
               end
            end
            PH_MODRM: begin
               if (opc_ff == OPC_TEST8 && reg_f == 3'd0) fl = fl | F_B;
               if (opc_ff == OPC_TEST32 && reg_f == 3'd0) fl = fl | F_P;
               flags_in = fl;
               mod_in = code_byte[7:6];
               case (code_byte[7:6])
                  2'd0: begin
                     if (adsz && rm == 3'd6) off = 4'd2;
                     if (!adsz && rm == 3'd5) off = 4'd4;
                  end
                  2'd1: off = 4'd1;
                  2'd2: off = adsz ? 4'd2 : 4'd4;
                  default: off = 4'd0;
               endcase
               sib = !adsz && rm == 3'd4 && code_byte[7:6] != 2'd3;
               imm = {3'd0, fl[1]} + {2'd0, fl[2], 1'b0} +
                     (fl[3] ? (opsz ? 4'd2 : 4'd4) : 4'd0);
               left_in = off + imm;
               if (sib) phase_in = PH_SIB;
               else if (off + imm == '0) fin = 1'b1;
               else phase_in = PH_TAIL;
            end
            PH_SIB: begin
               if (code_byte[2:0] == 3'd5 && mod_ff == 2'd0) left_in = left_ff + 4'd4;
               if (left_in == '0) fin = 1'b1; else phase_in = PH_TAIL;
            end
            PH_TAIL: begin
               if (left_ff != '0) left_in = left_ff - 4'd1;
               if (left_in == '0) fin = 1'b1; else phase_in = PH_TAIL;
            end
            default: begin
               if (is_prefix(code_byte)) begin
                  if (pfx_in >= max_prefixes) ovf = 1'b1;
                  else begin
                     pfx_in = pfx_in + 5'd1;
                     if (code_byte == OPC_OPSIZE) opsz_in = 1'b1;
                     if (code_byte == OPC_ADSIZE) adsz_in = 1'b1;
                  end
               end else begin
                  opc_in = code_byte;
                  if (code_byte == OPC_TWO_BYTE) phase_in = PH_EXT;
                  else begin
                     fl = tbl_one(code_byte); flags_in = fl;
                     if (code_byte >= 8'hA0 && code_byte <= 8'hA3) begin
                        opsz = adsz; opsz_in = adsz;
                     end
                     if (fl[4]) phase_in = PH_WORD;
                     else if (fl[0]) phase_in = PH_MODRM;
                     else begin
                        imm = {3'd0, fl[1]} + {2'd0, fl[2], 1'b0} +
                              (fl[3] ? (opsz ? 4'd2 : 4'd4) : 4'd0);
                        left_in = imm;
                        if (imm == '0) fin = 1'b1; else phase_in = PH_TAIL;
                     end
                  end
               end
            end
         endcase
         if (fin) begin
            sum = {1'b0, total_in} + {{(TOTAL_BITS-4){1'b0}}, len};
            total_in = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
            if (len == 5'd1 && (opc_in == OPC_INT3 || opc_in == OPC_NOP) && fill != 4'd15)
               fill = fill + 4'd1;
            fill_in = fill;
            endw = (fill > filler_limit) || (opc_in == 8'h00);
            if (endw) done_in = 1'b1;
            res_valid = 1'b1;
            res.insn_length = len;
            res.opcode_byte = opc_in;
            res.total_size = 16'(total_in);
            res.walk_end = endw;
         end
         if (ovf) begin
            done_in = 1'b1;
            res_valid = 1'b1;
            res.total_size = 16'(total_in);
            res.walk_end = 1'b1;
            res.prefix_error = 1'b1;
         end
         if (fin || ovf) begin
            phase_in = PH_PREFIX; flags_in = '0; opsz_in = 1'b0; adsz_in = 1'b0;
            opc_in = '0; mod_in = '0; left_in = '0; len_in = '0; pfx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX; flags_ff <= '0; opsz_ff <= 1'b0; adsz_ff <= 1'b0;
         opc_ff <= '0; mod_ff <= '0; left_ff <= '0; len_ff <= '0; pfx_ff <= '0;
         fill_ff <= '0; total_ff <= '0; done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; flags_ff <= flags_in; opsz_ff <= opsz_in;
         adsz_ff <= adsz_in; opc_ff <= opc_in; mod_ff <= mod_in; left_ff <= left_in;
         len_ff <= len_in; pfx_ff <= pfx_in; fill_ff <= fill_in;
         total_ff <= total_in; done_ff <= done_in;
      end
   end

endmodule

### rtl/x86_instruction_length_decoder_top.sv
// A result appears on rsp_ in the cycle after the last byte of an instruction is accepted.
// Throughput: one code byte per cycle while req_tready is high; the phase step is combinational logic.
// A one-entry output register decouples rsp_tready; input stalls only when full.
// Reset: synchronous, active high; clears state, counters and config to defaults.
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_top
// Byte-stream x86 length decoder with running function size.
// ----------------------------------------------------------------------------
module x86_instruction_length_decoder_top import xild_pkg::*; #(
   parameter int TOTAL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   input  logic        req_tuser,   // walk_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // insn_length[4:0], opcode_byte[12:5], total_size[28:13]
   output logic        rsp_tlast,   // walk_end
   output logic        rsp_tuser,   // prefix_error
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata
);

   logic [4:0] maxp_ff;
   logic [3:0] fill_lim_ff;
   logic       step, res_valid;
   result_type res;
   logic       vld_ff;
   result_type out_ff;

   assign req_tready = !vld_ff || rsp_tready;
   assign step = req_tvalid && req_tready;

   xild_core #(.TOTAL_BITS(TOTAL_BITS)) u_core (
      .clock(clock), .reset(reset), .step(step),
      .code_byte(req_tdata), .walk_start(req_tuser),
      .max_prefixes(maxp_ff), .filler_limit(fill_lim_ff),
      .res_valid(res_valid), .res(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         maxp_ff <= 5'd16; fill_lim_ff <= 4'd1; vld_ff <= 1'b0;
      end else begin
         if (csr_we && csr_addr == CSR_MAX_PREFIXES) maxp_ff <= csr_wdata;
         if (csr_we && csr_addr == CSR_FILLER_LIMIT) fill_lim_ff <= csr_wdata[3:0];
         if (req_tready) vld_ff <= step && res_valid;
      end
      if (req_tready && step && res_valid) out_ff <= res;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {3'd0, out_ff.total_size, out_ff.opcode_byte, out_ff.insn_length};
   assign rsp_tlast = out_ff.walk_end;
   assign rsp_tuser = out_ff.prefix_error;

endmodule

### rtl/xild_checker.sv
// ----------------------------------------------------------------------------
// xild_checker
// Port-level checks for the length decoder.
// ----------------------------------------------------------------------------
module xild_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("ready low with empty output");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[12:0] == 13'd0 && rsp_tlast)
      else $error("prefix error item malformed");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[4:0] != 5'd0)
      else $error("zero length");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("output dropped");
endmodule

bind x86_instruction_length_decoder_top xild_port_props u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
   .rsp_tuser(rsp_tuser)
);

### tb/sv/xild_checker.sv
// ----------------------------------------------------------------------------
// xild_checker
// Watches the byte and result streams of the length decoder, predicts each
// decoded instruction from its own copy of the decoder state and compares.
// ----------------------------------------------------------------------------
module xild_checker import xild_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata,
   output int          pending,
   output int          errors
);
   timeunit 1ns;
   timeprecision 1ps;

   result_type insn_queue[$];

   logic [4:0]  prefix_limit;
   logic [3:0]  nop_limit;
   phase_type   ph;
   logic [7:0]  flags;
   logic        opsize_seen;
   logic        adsize_seen;
   logic [7:0]  opcode;
   logic [1:0]  mod_saved;
   logic [3:0]  tail_left;
   logic [4:0]  insn_len;
   logic [4:0]  prefix_run;
   logic [3:0]  nop_run;
   logic [15:0] func_size;
   logic        walk_over;

   function automatic logic [7:0] one_byte_flags(input logic [7:0] b);
      if (b < 8'h40) begin
         if (b[2] == 1'b0) return F_M;
         if (b[2:0] == 3'd4) return F_B;
         if (b[2:0] == 3'd5) return F_P;
         return F_N;
      end
      if (b >= 8'h70 && b < 8'h80) return F_B;
      if (b >= 8'h84 && b < 8'h90) return F_M;
      if (b >= 8'hB0 && b < 8'hB8) return F_B;
      if (b >= 8'hB8 && b < 8'hC0) return F_P;
      if (b >= 8'hD8 && b < 8'hE0) return F_X;
      if (b >= 8'hE0 && b < 8'hE8) return F_B;
      if (b >= 8'hA0 && b < 8'hA4) return F_P;
      case (b)
         8'h62, 8'h63, 8'hC4, 8'hC5, 8'hD0, 8'hD1, 8'hD2, 8'hD3,
         8'hF6, 8'hF7, 8'hFE, 8'hFF: return F_M;
         8'h68, 8'hA9, 8'hE8, 8'hE9: return F_P;
         8'h69, 8'h81, 8'hC7: return F_M | F_P;
         8'h6A, 8'hA8, 8'hCD, 8'hD4, 8'hD5, 8'hEB: return F_B;
         8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6: return F_M | F_B;
         8'h9A, 8'hEA: return F_W | F_P;
         8'hC2, 8'hCA: return F_W;
         8'hC8: return F_B | F_W;
         default: return F_N;
      endcase
   endfunction

   function automatic logic [7:0] two_byte_flags(input logic [7:0] b);
      if (b >= 8'h30 && b < 8'h40) return F_N;
      if (b >= 8'h80 && b < 8'h90) return F_P;
      if (b >= 8'hC8 && b < 8'hD0) return F_N;
      if (b >= 8'h04 && b < 8'h0D) return F_N;
      if (b >= 8'h19 && b < 8'h20) return F_N;
      if (b >= 8'h77 && b < 8'h7C) return F_N;
      if (b >= 8'h70 && b < 8'h74) return F_M | F_B;
      case (b)
         8'h0E, 8'h25, 8'h27, 8'hA0, 8'hA1, 8'hA2, 8'hA6, 8'hA7, 8'hA8,
         8'hA9, 8'hAA, 8'hB8, 8'hB9, 8'hFF: return F_N;
         8'h0F, 8'hA4, 8'hAC, 8'hBA, 8'hC2, 8'hC4, 8'hC5, 8'hC6: return F_M | F_B;
         default: return F_M;
      endcase
   endfunction

   function automatic logic seg_or_rep(input logic [7:0] b);
      case (b)
         8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'h66, 8'h67,
         8'hF0, 8'hF2, 8'hF3: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [3:0] imm_bytes(input logic [7:0] f, input logic osz);
      logic [3:0] n;
      n = 4'd0;
      if (f & F_B) n = n + 4'd1;
      if (f & F_W) n = n + 4'd2;
      if (f & F_P) n = n + (osz ? 4'd2 : 4'd4);
      return n;
   endfunction

   task automatic clear_insn();
      ph = PH_PREFIX;
      flags = F_N;
      opsize_seen = 1'b0;
      adsize_seen = 1'b0;
      opcode = 8'h00;
      mod_saved = 2'd0;
      tail_left = 4'd0;
      insn_len = 5'd0;
      prefix_run = 5'd0;
   endtask

   task automatic close_insn(output logic got, output result_type r);
      logic [16:0] sum;
      sum = {1'b0, func_size} + {12'd0, insn_len};
      func_size = sum[16] ? 16'hFFFF : sum[15:0];
      if (insn_len == 5'd1 && (opcode == OPC_INT3 || opcode == OPC_NOP) && nop_run != 4'd15)
         nop_run = nop_run + 4'd1;
      r.insn_length = insn_len;
      r.opcode_byte = opcode;
      r.total_size = func_size;
      r.walk_end = (nop_run > nop_limit) || (opcode == 8'h00);
      r.prefix_error = 1'b0;
      if (r.walk_end) walk_over = 1'b1;
      got = 1'b1;
      clear_insn();
   endtask

   task automatic tail_check(output logic got, output result_type r);
      if (tail_left == 4'd0) begin
         close_insn(got, r);
      end else begin
         ph = PH_TAIL;
      end
   endtask

   task automatic past_escape(output logic got, output result_type r);
      if (flags & F_M) begin
         ph = PH_MODRM;
      end else begin
         tail_left = imm_bytes(flags, opsize_seen);
         tail_check(got, r);
      end
   endtask

   task automatic after_opcode(output logic got, output result_type r);
      if (flags & F_X) ph = PH_WORD;
      else past_escape(got, r);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic st,
                              output logic got, output result_type r);
      logic [3:0] disp;
      got = 1'b0;
      r = '0;
      if (st) begin
         func_size = 16'd0;
         nop_run = 4'd0;
         walk_over = 1'b0;
         clear_insn();
      end
      if (walk_over) return;
      if (insn_len != 5'd31) insn_len = insn_len + 5'd1;
      case (ph)
         PH_EXT: begin
            flags = two_byte_flags(b);
            after_opcode(got, r);
         end
         PH_WORD: past_escape(got, r);
         PH_MODRM: begin
            if (opcode == OPC_TEST8 && b[5:3] == 3'd0) flags = flags | F_B;
            if (opcode == OPC_TEST32 && b[5:3] == 3'd0) flags = flags | F_P;
            mod_saved = b[7:6];
            disp = 4'd0;
            case (b[7:6])
               2'd0: begin
                  if (adsize_seen && b[2:0] == 3'd6) disp = 4'd2;
                  if (!adsize_seen && b[2:0] == 3'd5) disp = 4'd4;
               end
               2'd1: disp = 4'd1;
               2'd2: disp = adsize_seen ? 4'd2 : 4'd4;
               default: disp = 4'd0;
            endcase
            tail_left = disp + imm_bytes(flags, opsize_seen);
            if (!adsize_seen && b[2:0] == 3'd4 && b[7:6] != 2'd3) ph = PH_SIB;
            else tail_check(got, r);
         end
         PH_SIB: begin
            if (b[2:0] == 3'd5 && mod_saved == 2'd0) tail_left = tail_left + 4'd4;
            tail_check(got, r);
         end
         PH_TAIL: begin
            if (tail_left != 4'd0) tail_left = tail_left - 4'd1;
            tail_check(got, r);
         end
         default: begin
            if (seg_or_rep(b)) begin
               if (prefix_run >= prefix_limit) begin
                  walk_over = 1'b1;
                  r.walk_end = 1'b1;
                  r.prefix_error = 1'b1;
                  r.total_size = func_size;
                  got = 1'b1;
                  clear_insn();
               end else begin
                  prefix_run = prefix_run + 5'd1;
                  if (b == OPC_OPSIZE) opsize_seen = 1'b1;
                  if (b == OPC_ADSIZE) adsize_seen = 1'b1;
               end
            end else begin
               opcode = b;
               if (b == OPC_TWO_BYTE) begin
                  ph = PH_EXT;
               end else begin
                  flags = one_byte_flags(b);
                  if (b >= 8'hA0 && b <= 8'hA3) opsize_seen = adsize_seen;
                  after_opcode(got, r);
               end
            end
         end
      endcase
   endtask

   assign pending = insn_queue.size();

   initial errors = 0;

   always @(posedge clock) begin
      logic got;
      result_type want, seen;
      if (reset) begin
         insn_queue.delete();
         prefix_limit <= 5'd16;
         nop_limit <= 4'd1;
         clear_insn();
         nop_run = 4'd0;
         func_size = 16'd0;
         walk_over = 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_MAX_PREFIXES) prefix_limit <= csr_wdata;
            else nop_limit <= csr_wdata[3:0];
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser, got, want);
            if (got) insn_queue.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.insn_length = rsp_tdata[4:0];
            seen.opcode_byte = rsp_tdata[12:5];
            seen.total_size = rsp_tdata[28:13];
            seen.walk_end = rsp_tlast;
            seen.prefix_error = rsp_tuser;
            if (insn_queue.size() == 0) begin
               $display("%t: unexpected result, expected none, actual %p",
                        $realtime, seen);
               errors = errors + 1;
            end else begin
               want = insn_queue.pop_front();
               if (seen !== want) begin
                  $display("%t: result mismatch, expected %p, actual %p",
                           $realtime, want, seen);
                  errors = errors + 1;
               end
            end
         end
      end
   end

endmodule

### tb/sv/tb_x86_instruction_length_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_x86_instruction_length_decoder_top
// Drives byte streams of prefixes, opcodes and operand tails through the
// length decoder under several register settings, with random stalls.
// ----------------------------------------------------------------------------
module tb_x86_instruction_length_decoder_top import xild_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // code_byte
   logic        req_tuser = 1'b0;    // walk_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // insn_length, opcode_byte, total_size
   logic        rsp_tlast;           // walk_end
   logic        rsp_tuser;           // prefix_error
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_MAX_PREFIXES;
   logic [4:0]  csr_wdata = 5'd0;

   int   pending;
   int   errors;
   logic calm = 1'b0;
   logic restart_due = 1'b1;

   always #2 clock = ~clock;

   x86_instruction_length_decoder_top dut (.*);

   xild_checker checker_i (.*);

   // receiver stalls in bursts
   always @(negedge clock) begin
      int n;
      if (!calm && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 10);
         rsp_tready <= 1'b0;
         repeat (n) @(negedge clock);
      end
      rsp_tready <= 1'b1;
   end

   always @(posedge clock)
      if (rsp_tvalid && rsp_tready && rsp_tlast) restart_due <= 1'b1;

   task automatic send_byte(input logic [7:0] b, input logic st);
      int n;
      if (!calm && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 10);
         req_tvalid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tuser = st;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic csr_write(input logic a, input logic [4:0] v);
      csr_we = 1'b1;
      csr_addr = a;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 14) begin
         case ($urandom_range(0, 10))
            0: return 8'h2E;  1: return 8'h3E;  2: return 8'h36;
            3: return 8'h26;  4: return 8'h64;  5: return 8'h65;
            6: return 8'hF0;  7: return 8'hF2;  8: return 8'hF3;
            9: return OPC_OPSIZE;
            default: return OPC_ADSIZE;
         endcase
      end
      if (r < 20) return OPC_TWO_BYTE;
      if (r < 30) begin
         case ($urandom_range(0, 6))
            0: return OPC_INT3;
            1: return OPC_NOP;
            2: return OPC_TEST8;
            3: return OPC_TEST32;
            4: return 8'hD8 + 8'($urandom_range(0, 7));
            5: return 8'hA0 + 8'($urandom_range(0, 3));
            default: return 8'h04 + 8'($urandom_range(0, 3)) * 8'h40;
         endcase
      end
      b = 8'($urandom_range(0, 255));
      if (b == 8'h00 && $urandom_range(0, 9) != 0) b = 8'h8B;
      return b;
   endfunction

   task automatic random_run(input int count);
      logic st;
      for (int i = 0; i < count; i++) begin
         st = restart_due || ($urandom_range(0, 49) == 0);
         if (st) restart_due = 1'b0;
         send_byte(pick_byte(), st);
      end
   endtask

   initial begin
      #2000000;
      $display("x86_instruction_length_decoder_top regression: fail");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: nops, prefixed forms, special opcodes
      send_byte(OPC_NOP, 1'b1);
      send_byte(OPC_OPSIZE, 1'b1);
      send_byte(OPC_ADSIZE, 1'b0);
      send_byte(8'hA1, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(OPC_TEST32, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h25, 1'b0);
      for (int i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
      send_byte(OPC_TEST8, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(OPC_TWO_BYTE, 1'b0);
      send_byte(8'h85, 1'b0);
      for (int i = 0; i < 4; i++) send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h90, 1'b0);  // taken as the ModRM byte of opcode 00
      drain();

      // prefix run long enough to saturate the instruction length
      csr_write(CSR_MAX_PREFIXES, 5'd31);
      csr_write(CSR_FILLER_LIMIT, 5'd15);
      send_byte(8'hF3, 1'b1);
      for (int i = 0; i < 30; i++) send_byte(8'h2E, 1'b0);
      send_byte(8'hC3, 1'b0);
      for (int i = 0; i < 32; i++) send_byte(8'h64, 1'b0);
      random_run(250);
      drain();

      csr_write(CSR_MAX_PREFIXES, 5'd1);
      csr_write(CSR_FILLER_LIMIT, 5'd0);
      send_byte(OPC_OPSIZE, 1'b1);
      send_byte(OPC_ADSIZE, 1'b0);
      random_run(300);
      drain();

      // zero limit: every prefix overflows
      csr_write(CSR_MAX_PREFIXES, 5'd0);
      csr_write(CSR_FILLER_LIMIT, 5'd3);
      send_byte(8'h26, 1'b1);
      random_run(250);
      drain();

      csr_write(CSR_MAX_PREFIXES, 5'd4);
      csr_write(CSR_FILLER_LIMIT, 5'd7);
      random_run(380);
      calm = 1'b1;
      random_run(170);
      drain();

      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("x86_instruction_length_decoder_top regression: pass");
      end else begin
         $display("x86_instruction_length_decoder_top regression: fail");
      end
      $finish;
   end

endmodule
